/* rtl/core/mrw_pkg.sv */
package mrw_pkg;

	localparam int unsigned SENDER_SLOTS_DEF = 8;
	localparam int unsigned WIN_BITS = 64;
	localparam logic [31:0] EVICT_IDLE_RST = 32'd60000;

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_CLEAN = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_DUP    = 2'd1,
		VERDICT_BELOW  = 2'd2,
		VERDICT_NOSLOT = 2'd3
	} verdict_t;

	typedef struct packed {
		logic        command;
		logic [31:0] source_address;
		logic [63:0] packet_counter;
		logic [31:0] time_now_ms;
	} mrw_req_t;

	typedef struct packed {
		logic [1:0]  verdict;
		logic        table_dirty;
		logic        slot_evicted;
		logic [31:0] eviction_count;
		logic [31:0] denied_count;
	} mrw_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic req_load;
		logic scan_run;
		logic decide;
		logic diff;
		logic update;
		logic clean;
		logic rsp_load;
	} mrw_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_clean;
		logic hit;
		logic last;
		logic deny;
		logic out_free;
	} mrw_status_t;

endpackage

/* rtl/core/mrw_ctrl.sv */
module mrw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mrw_pkg::mrw_status_t st,
	output mrw_pkg::mrw_cmd_t    cmd
);
	import mrw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DIFF,
		ST_UPDATE,
		ST_CLEAN,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   req_ready_q;
	logic   accept;

	assign req_ready = req_ready_q;
	assign accept    = req_ready_q && req_valid;

	always_comb begin
		cmd          = '0;
		cmd.req_load = accept;
		case (state_q)
			ST_SCAN:   cmd.scan_run = 1'b1;
			ST_DECIDE: cmd.decide   = 1'b1;
			ST_DIFF:   cmd.diff     = 1'b1;
			ST_UPDATE: cmd.update   = 1'b1;
			ST_CLEAN:  cmd.clean    = 1'b1;
			ST_RESULT: cmd.rsp_load = st.out_free;
			default:   cmd.scan_run = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_ready_q <= 1'b0;
						state_q     <= st.req_clean ? ST_CLEAN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (st.hit) begin
						state_q <= ST_DIFF;
					end else if (st.last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: state_q <= st.deny ? ST_RESULT : ST_DIFF;
				ST_DIFF:   state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_RESULT;
				ST_CLEAN:  state_q <= ST_RESULT;
				ST_RESULT: begin
					if (st.out_free) begin
						state_q     <= ST_IDLE;
						req_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					req_ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

/* rtl/core/mrw_dp.sv */
module mrw_dp #(
	parameter int unsigned SENDER_SLOTS = mrw_pkg::SENDER_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mrw_pkg::mrw_cmd_t    cmd,
	output mrw_pkg::mrw_status_t st,
	input  mrw_pkg::mrw_req_t    req_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mrw_pkg::mrw_rsp_t    rsp_data,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata
);
	import mrw_pkg::*;

	localparam int unsigned IDX_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(SENDER_SLOTS + 1);

	typedef struct packed {
		logic [31:0]         src;
		logic [63:0]         hw;
		logic [WIN_BITS-1:0] win;
		logic [31:0]         last;
	} entry_t;

	entry_t mem [SENDER_SLOTS];

	// control state
	logic [CNT_W-1:0]        scan_cnt_q;
	logic                    rd_vld_s1;
	logic [SENDER_SLOTS-1:0] used_q;
	logic                    dirty_q;
	logic [31:0]             evict_cnt_q;
	logic [31:0]             deny_cnt_q;
	logic [31:0]             cfg_q;
	logic                    rsp_valid_q;

	// payload
	mrw_req_t            req_q;
	entry_t              rd_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [IDX_W-1:0]    slot_q;
	logic                new_q;
	logic                evicted_q;
	logic [63:0]         hw_q;
	logic [WIN_BITS-1:0] win_q;
	logic [IDX_W-1:0]    oldest_idx_q;
	logic [31:0]         oldest_age_q;
	logic                up_s2;
	logic [63:0]         d_s2;
	logic [1:0]          verdict_q;
	mrw_rsp_t            rsp_q;

	logic                rd_en;
	logic                eval;
	logic                slot_free;
	logic                src_match;
	logic [31:0]         age;
	logic                deny;
	logic                dirty_set;
	logic                ctr_gt;
	entry_t              wr_entry;
	logic [1:0]          upd_verdict;
	logic [6:0]          dm1;
	logic [WIN_BITS-1:0] bit_mask;
	logic                d_big;
	logic                d_exact;

	assign rd_en     = cmd.scan_run && (scan_cnt_q < CNT_W'(SENDER_SLOTS));
	assign eval      = rd_vld_s1 && cmd.scan_run;
	assign slot_free = !used_q[rd_idx_s1];
	assign src_match = rd_s1.src == req_q.source_address;
	assign age       = req_q.time_now_ms - rd_s1.last;
	assign deny      = oldest_age_q < cfg_q;
	assign ctr_gt    = req_q.packet_counter > hw_q;

	assign st.req_clean = req_data.command == CMD_CLEAN;
	assign st.hit       = eval && (slot_free || src_match);
	assign st.last      = eval && (rd_idx_s1 == IDX_W'(SENDER_SLOTS - 1));
	assign st.deny      = deny;
	assign st.out_free  = !rsp_valid_q || rsp_ready;

	// window arithmetic on the registered difference
	assign dm1      = d_s2[6:0] - 7'd1;
	assign bit_mask = WIN_BITS'(1) << dm1[5:0];
	assign d_big    = (|d_s2[63:7]) || (d_s2[6:0] > 7'd64);
	assign d_exact  = d_s2 == 64'd64;

	always_comb begin
		wr_entry.src  = req_q.source_address;
		wr_entry.hw   = hw_q;
		wr_entry.win  = win_q;
		wr_entry.last = req_q.time_now_ms;
		upd_verdict   = VERDICT_ACCEPT;
		dirty_set     = 1'b0;
		if (new_q) begin
			wr_entry.hw  = req_q.packet_counter;
			wr_entry.win = '0;
			dirty_set    = 1'b1;
		end else if (up_s2) begin
			wr_entry.hw = req_q.packet_counter;
			dirty_set   = 1'b1;
			if (d_big) begin
				wr_entry.win = '0;
			end else if (d_exact) begin
				wr_entry.win = {1'b1, {(WIN_BITS-1){1'b0}}};
			end else begin
				wr_entry.win = (win_q << d_s2[5:0]) | bit_mask;
			end
		end else if (d_s2 == 64'd0) begin
			upd_verdict = VERDICT_DUP;
		end else if (d_big) begin
			upd_verdict = VERDICT_BELOW;
		end else if (|(win_q & bit_mask)) begin
			upd_verdict = VERDICT_DUP;
		end else begin
			wr_entry.win = win_q | bit_mask;
		end
	end

	// slot table, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			mem[slot_q] <= wr_entry;
		end
		if (rd_en) begin
			rd_s1 <= mem[scan_cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req_data;
		end
		rd_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		if (st.hit) begin
			slot_q    <= rd_idx_s1;
			new_q     <= slot_free;
			evicted_q <= 1'b0;
			hw_q      <= rd_s1.hw;
			win_q     <= rd_s1.win;
		end else if (cmd.decide) begin
			slot_q    <= oldest_idx_q;
			new_q     <= 1'b1;
			evicted_q <= !deny;
		end else if (cmd.clean) begin
			evicted_q <= 1'b0;
		end
		if (eval && !st.hit && (rd_idx_s1 == IDX_W'(0) || age > oldest_age_q)) begin
			oldest_idx_q <= rd_idx_s1;
			oldest_age_q <= age;
		end
		if (cmd.diff) begin
			up_s2 <= ctr_gt;
			d_s2  <= ctr_gt ? req_q.packet_counter - hw_q : hw_q - req_q.packet_counter;
		end
		if (cmd.update) begin
			verdict_q <= upd_verdict;
		end else if (cmd.decide) begin
			verdict_q <= VERDICT_NOSLOT;
		end else if (cmd.clean) begin
			verdict_q <= VERDICT_ACCEPT;
		end
		if (cmd.rsp_load) begin
			rsp_q.verdict        <= verdict_q;
			rsp_q.table_dirty    <= dirty_q;
			rsp_q.slot_evicted   <= evicted_q;
			rsp_q.eviction_count <= evict_cnt_q;
			rsp_q.denied_count   <= deny_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			rd_vld_s1   <= 1'b0;
			used_q      <= '0;
			dirty_q     <= 1'b0;
			evict_cnt_q <= '0;
			deny_cnt_q  <= '0;
			cfg_q       <= EVICT_IDLE_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.req_load) begin
				scan_cnt_q <= '0;
			end else if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= rd_en;
			if (cmd.update) begin
				used_q[slot_q] <= 1'b1;
			end
			if (cmd.clean) begin
				dirty_q <= 1'b0;
			end else if (cmd.update && dirty_set) begin
				dirty_q <= 1'b1;
			end
			if (cmd.decide) begin
				if (deny) begin
					deny_cnt_q <= deny_cnt_q + 32'd1;
				end else begin
					evict_cnt_q <= evict_cnt_q + 32'd1;
				end
			end
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* rtl/core/multi_sender_replay_window.sv */
// sequence: a check scans the slots in order until its sender or a free slot is found, then
// compares counters and updates the window; with no match in a full table it first decides
// on a recycle, and a refused recycle goes straight to the result; a mark-clean beat skips the scan
// throughput: one beat at a time, set by the slot scan that reads one table row a cycle;
// a finished result waits in the output register while the next beat is taken
// reset: asynchronous, all slots free, counts and dirty flag zero, idle limit 60000 ms
module multi_sender_replay_window #(
	parameter int unsigned SENDER_SLOTS = mrw_pkg::SENDER_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// check / mark-clean beats
	input  logic              req_valid,
	output logic              req_ready,
	input  mrw_pkg::mrw_req_t req_data,
	// result beats
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output mrw_pkg::mrw_rsp_t rsp_data,
	// minimum idle time before a slot may be recycled
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);
	import mrw_pkg::*;

	mrw_cmd_t    cmd;
	mrw_status_t st;

	// sequencer: scan, eviction decision, counter compare, window update, mark-clean, result
	mrw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// slot store, oldest-slot tracking, window arithmetic and the wrapping counts
	mrw_dp #(
		.SENDER_SLOTS (SENDER_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

endmodule

/* test/replay_window_checker.sv */
`timescale 1ns / 100ps

module replay_window_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  mrw_pkg::mrw_req_t req_data,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  mrw_pkg::mrw_rsp_t rsp_data,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	output int                fail_count,
	output int                outstanding,
	output int                results_seen,
	output int                recycles_seen,
	output int                refusals_seen,
	output int                replays_seen
);
	import mrw_pkg::*;

	localparam int SLOTS = SENDER_SLOTS_DEF;

	// shadow of the sender table
	bit        occupied  [SLOTS];
	bit        has_ctr   [SLOTS];
	bit [31:0] sender    [SLOTS];
	bit [63:0] top_ctr   [SLOTS];
	bit [63:0] seen_map  [SLOTS];
	bit [31:0] last_heard[SLOTS];
	bit        dirty;
	bit [31:0] recycles;
	bit [31:0] refusals;
	bit [31:0] idle_limit;

	mrw_rsp_t  pending_rsp[$];
	int        errors;
	int        n_results, n_recycles, n_refusals, n_replays;

	function automatic void take_slot(input int s, input bit [31:0] src, input bit [31:0] now);
		occupied[s]   = 1'b1;
		sender[s]     = src;
		top_ctr[s]    = '0;
		seen_map[s]   = '0;
		has_ctr[s]    = 1'b0;
		last_heard[s] = now;
		dirty         = 1'b1;
	endfunction

	function automatic verdict_t judge_counter(input int s, input bit [63:0] ctr);
		bit [63:0] shift;
		bit [63:0] delta;
		bit [63:0] mask;
		if (!has_ctr[s]) begin
			has_ctr[s] = 1'b1;
			top_ctr[s] = ctr;
			dirty      = 1'b1;
			return VERDICT_ACCEPT;
		end
		if (ctr > top_ctr[s]) begin
			shift = ctr - top_ctr[s];
			if (shift > WIN_BITS)
				seen_map[s] = '0;
			else if (shift == WIN_BITS)
				seen_map[s] = 64'h1 << (WIN_BITS - 1);
			else
				seen_map[s] = (seen_map[s] << shift) | (64'h1 << (shift - 1));
			top_ctr[s] = ctr;
			dirty      = 1'b1;
			return VERDICT_ACCEPT;
		end
		delta = top_ctr[s] - ctr;
		if (delta == 0)
			return VERDICT_DUP;
		if (delta > WIN_BITS)
			return VERDICT_BELOW;
		mask = 64'h1 << (delta - 1);
		if ((seen_map[s] & mask) != 0)
			return VERDICT_DUP;
		seen_map[s] |= mask;
		return VERDICT_ACCEPT;
	endfunction

	function automatic mrw_rsp_t apply_beat(input mrw_req_t r);
		mrw_rsp_t  res;
		int        s;
		int        oldest;
		bit [31:0] age_i;
		bit [31:0] age_old;
		res = '0;
		res.verdict = VERDICT_ACCEPT;
		if (r.command == CMD_CLEAN) begin
			dirty = 1'b0;
		end else begin
			s      = -1;
			oldest = 0;
			for (int i = 0; i < SLOTS && s < 0; i++) begin
				age_i   = r.time_now_ms - last_heard[i];
				age_old = r.time_now_ms - last_heard[oldest];
				if (occupied[i] && sender[i] == r.source_address) begin
					s = i;
				end else if (!occupied[i]) begin
					take_slot(i, r.source_address, r.time_now_ms);
					s = i;
				end else if (age_i > age_old) begin
					oldest = i;
				end
			end
			if (s < 0) begin
				age_old = r.time_now_ms - last_heard[oldest];
				if (age_old < idle_limit) begin
					refusals++;
					res.verdict = VERDICT_NOSLOT;
				end else begin
					recycles++;
					res.slot_evicted = 1'b1;
					take_slot(oldest, r.source_address, r.time_now_ms);
					s = oldest;
				end
			end
			if (s >= 0) begin
				last_heard[s] = r.time_now_ms;
				res.verdict   = judge_counter(s, r.packet_counter);
			end
		end
		res.table_dirty    = dirty;
		res.eviction_count = recycles;
		res.denied_count   = refusals;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < 40)
			$display("%0t: result %0d %s is %0h, predicted %0h", $realtime, n_results, field,
				got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		mrw_rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				occupied[i]   = 1'b0;
				has_ctr[i]    = 1'b0;
				sender[i]     = '0;
				top_ctr[i]    = '0;
				seen_map[i]   = '0;
				last_heard[i] = '0;
			end
			dirty      = 1'b0;
			recycles   = '0;
			refusals   = '0;
			idle_limit = EVICT_IDLE_RST;
			pending_rsp.delete();
			errors     = 0;
			n_results  = 0;
			n_recycles = 0;
			n_refusals = 0;
			n_replays  = 0;
		end else begin
			if (cfg_we)
				idle_limit = cfg_wdata;
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("arrived unasked, verdict", rsp_data.verdict, '0);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp_data.verdict !== want.verdict)
						report_mismatch("verdict", rsp_data.verdict, want.verdict);
					if (rsp_data.table_dirty !== want.table_dirty)
						report_mismatch("table_dirty", rsp_data.table_dirty, want.table_dirty);
					if (rsp_data.slot_evicted !== want.slot_evicted)
						report_mismatch("slot_evicted", rsp_data.slot_evicted,
							want.slot_evicted);
					if (rsp_data.eviction_count !== want.eviction_count)
						report_mismatch("eviction_count", rsp_data.eviction_count,
							want.eviction_count);
					if (rsp_data.denied_count !== want.denied_count)
						report_mismatch("denied_count", rsp_data.denied_count,
							want.denied_count);
				end
				n_results++;
			end
			if (req_valid && req_ready) begin
				want = apply_beat(req_data);
				if (want.slot_evicted)
					n_recycles++;
				if (want.verdict == VERDICT_NOSLOT)
					n_refusals++;
				if (want.verdict == VERDICT_DUP || want.verdict == VERDICT_BELOW)
					n_replays++;
				pending_rsp.push_back(want);
			end
		end
		// published after the edge so that readers see a settled value
		fail_count    <= errors;
		outstanding   <= pending_rsp.size();
		results_seen  <= n_results;
		recycles_seen <= n_recycles;
		refusals_seen <= n_refusals;
		replays_seen  <= n_replays;
	end

endmodule

/* test/multi_sender_replay_window_tb.sv */
`timescale 1ns / 100ps

module multi_sender_replay_window_tb;
	import mrw_pkg::*;

	localparam int POOL   = 12;                    // known senders, more than there are slots
	localparam int SETTLE = SENDER_SLOTS_DEF + 12; // worst case latency plus margin
	localparam int LIMIT  = 600000;                // cycles, several times the slowest run

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	mrw_req_t req_data  = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	mrw_rsp_t rsp_data;
	logic     cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	int fail_count;
	int outstanding;
	int results_seen;
	int recycles_seen;
	int refusals_seen;
	int replays_seen;
	int cycles = 0;

	// when set, neither side idles
	bit quiet = 1'b0;

	// sender pool with a rough idea of each sender's high water
	bit [31:0] pool_addr[POOL];
	bit [63:0] pool_ctr [POOL];
	bit [31:0] tnow;

	always #5 clk = ~clk;

	multi_sender_replay_window u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	replay_window_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_data      (req_data),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp_data      (rsp_data),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.results_seen  (results_seen),
		.recycles_seen (recycles_seen),
		.refusals_seen (refusals_seen),
		.replays_seen  (replays_seen)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("multi_sender_replay_window test failed");
			$finish;
		end
	end

	// result side: random stall before each beat, then ready held until a beat is taken
	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// present one beat and hold it until taken; the gap after it is drawn here, so that a
	// back to back beat keeps valid high without dropping it in the same step
	task automatic send_beat(input mrw_req_t r);
		int gap;
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic check_beat(input bit [31:0] src, input bit [63:0] ctr, input bit [31:0] now);
		mrw_req_t r;
		r.command        = CMD_CHECK;
		r.source_address = src;
		r.packet_counter = ctr;
		r.time_now_ms    = now;
		send_beat(r);
	endtask

	task automatic clean_beat();
		mrw_req_t r;
		r.command        = CMD_CLEAN;
		r.source_address = $urandom;
		r.packet_counter = {$urandom, $urandom};
		r.time_now_ms    = $urandom;
		send_beat(r);
	endtask

	// hold the sender off until every predicted result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic set_idle_limit(input bit [31:0] ms);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= ms;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly known senders with counters around their high water, so the window logic is
	// exercised; some stray senders, stray times and wild counters as noise
	task automatic random_beats(input int count, input int step_max);
		mrw_req_t r;
		int       p;
		int       pick;
		repeat (count) begin
			if ($urandom_range(0, 99) == 0)
				quiet = ~quiet;
			if ($urandom_range(0, 11) == 0) begin
				clean_beat();
			end else begin
				p    = $urandom_range(0, POOL - 1);
				tnow = tnow + $urandom_range(0, step_max);
				r.command        = CMD_CHECK;
				r.source_address = ($urandom_range(0, 15) == 0) ? $urandom : pool_addr[p];
				r.time_now_ms    = ($urandom_range(0, 31) == 0) ? $urandom : tnow;
				pick = $urandom_range(0, 19);
				case (pick)
					0: r.packet_counter = {$urandom, $urandom};
					1: r.packet_counter = '0;
					2: r.packet_counter = '1;
					3: r.packet_counter = pool_ctr[p] + WIN_BITS;
					4: r.packet_counter = pool_ctr[p] - WIN_BITS;
					5: r.packet_counter = pool_ctr[p] - WIN_BITS - 1;
					default: r.packet_counter = pool_ctr[p] + 64'($urandom_range(0, 90)) - 64'd60;
				endcase
				if (r.packet_counter > pool_ctr[p])
					pool_ctr[p] = r.packet_counter;
				send_beat(r);
			end
		end
	endtask

	initial begin : stimulus
		for (int i = 0; i < POOL; i++) begin
			pool_addr[i] = $urandom;
			pool_ctr[i]  = {$urandom, $urandom} >> $urandom_range(0, 63);
		end
		pool_addr[0] = '0;
		pool_addr[1] = '1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: window corner cases on one sender, with the reset idle limit
		clean_beat();                                    // clean on an empty table
		check_beat(32'h0000_0000, 64'd0, 32'd0);         // first packet of a slot
		check_beat(32'h0000_0000, 64'd0, 32'd1);         // equal to high water
		check_beat(32'h0000_0000, 64'd64, 32'd2);        // jump of exactly a window
		check_beat(32'h0000_0000, 64'd0, 32'd3);         // old high water, now bit 63
		check_beat(32'h0000_0000, 64'd200, 32'd4);       // jump beyond the window
		check_beat(32'h0000_0000, 64'd135, 32'd5);       // one past the bottom
		check_beat(32'h0000_0000, 64'd199, 32'd6);       // inside the window
		check_beat(32'h0000_0000, 64'd199, 32'd7);       // replay inside the window
		clean_beat();
		check_beat(32'h0000_0000, 64'd198, 32'd8);       // in window accept keeps it clean
		check_beat(32'h0000_0000, '1, 32'd9);            // counter at its top
		// fill the table, all at one time so the oldest choice sees ties
		for (int k = 1; k < SENDER_SLOTS_DEF; k++)
			check_beat((k == SENDER_SLOTS_DEF - 1) ? 32'hFFFF_FFFF : 32'h1000_0000 * k,
				64'h8000_0000_0000_0000 + k, 32'd100);
		check_beat(32'hA5A5_5A5A, 64'd1, 32'd1000);      // table full, nobody idle long enough
		check_beat(32'hA5A5_5A5A, 64'd1, 32'hFFFF_FFFF); // idle slot recycled
		check_beat(32'h5A5A_A5A5, 64'd5, 32'hFFFF_FFFF); // tie broken by lowest index

		// random phases over a spread of idle limits, extremes included
		tnow = $urandom;
		set_idle_limit(32'd0);
		random_beats(350, 3000);
		set_idle_limit(32'd1000);
		random_beats(350, 400);
		set_idle_limit(32'hFFFF_FFFF);
		random_beats(250, 50000);
		set_idle_limit($urandom_range(1, 200000));
		random_beats(350, 20000);
		set_idle_limit(EVICT_IDLE_RST);
		random_beats(300, 25000);
		set_idle_limit(32'd5);
		random_beats(330, 4);

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("%0d results checked: %0d slot recycles, %0d refused, %0d replays caught",
			results_seen, recycles_seen, refusals_seen, replays_seen);
		$display("idle limits used: reset value, zero, 1000, all ones, a random one and 5 ms");
		if (fail_count == 0) begin
			$display("multi_sender_replay_window test passed");
		end else begin
			$display("multi_sender_replay_window test failed");
		end
		$finish;
	end

endmodule
